// ===== src/asoc_pkg.sv =====
// ----------------------------------------------------------------------------
// asoc_pkg
// Shared types and constants of the source-over compositing pipeline.
// ----------------------------------------------------------------------------
package asoc_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumW    = 33;
  localparam int unsigned DenW    = 25;
  localparam int unsigned QuotW   = 8;
  localparam int unsigned Lanes   = 4;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned DivStages     = QuotW / StepsPerStage;

  localparam logic [7:0]  ALPHA_ONE = 8'd255;
  localparam logic [15:0] ALPHA_SQ  = 16'd65025;
  localparam logic [DenW-1:0] ALPHA_DIV = DenW'(130050);
  localparam logic [DenW-1:0] MCOPY_DIV = DenW'(510);

  // Lane that carries the alpha quotient; lanes below it are red, green, blue.
  localparam int unsigned AlphaLane = 3;

  typedef enum logic [1:0] {
    MODE_COPY       = 2'd0,
    MODE_BLEND      = 2'd1,
    MODE_MASK_BLEND = 2'd2,
    MODE_MASK_COPY  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    SEL_DIV,
    SEL_SRC,
    SEL_SRC_DIVA,
    SEL_DST,
    SEL_ZERO
  } sel_e;

  typedef struct packed {
    logic [ChanW-1:0] sr;
    logic [ChanW-1:0] sg;
    logic [ChanW-1:0] sb;
    logic [ChanW-1:0] sa;
    logic [ChanW-1:0] dr;
    logic [ChanW-1:0] dg;
    logic [ChanW-1:0] db;
    logic [ChanW-1:0] da;
    logic [ChanW-1:0] ma;
  } pix_in_t;

  typedef struct packed {
    sel_e             sel;
    logic [ChanW-1:0] sr;
    logic [ChanW-1:0] sg;
    logic [ChanW-1:0] sb;
    logic [ChanW-1:0] sa;
    logic [ChanW-1:0] dr;
    logic [ChanW-1:0] dg;
    logic [ChanW-1:0] db;
    logic [ChanW-1:0] da;
  } side_t;

  typedef struct packed {
    logic            qbit;
    logic [NumW-1:0] rem;
  } step_t;

  // One restoring division step for quotient bit position pos.
  function automatic step_t div_step(logic [NumW-1:0] rem, logic [DenW-1:0] den,
                                     int unsigned pos);
    logic [NumW-1:0] sh;
    step_t           res;
    sh = NumW'(den) << pos;
    if (rem >= sh) begin
      res.qbit = 1'b1;
      res.rem  = rem - sh;
    end else begin
      res.qbit = 1'b0;
      res.rem  = rem;
    end
    return res;
  endfunction

endpackage

// ===== src/asoc_front.sv =====
// ----------------------------------------------------------------------------
// asoc_front
// Four register stages that form the dividend and divisor of every lane.
// ----------------------------------------------------------------------------
module asoc_front import asoc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  mode_e               mode_i,
  input  pix_in_t             px_i,
  output logic                valid_o,
  output logic [NumW-1:0]     num_o [Lanes],
  output logic [DenW-1:0]     den_o [Lanes],
  output side_t               side_o
);

  // Stage 1: effective source alpha.
  logic        s1_valid_q;
  logic [15:0] s1_s_q, s1_s_d;
  pix_in_t     s1_px_q;
  mode_e       s1_mode_q;

  // Stage 2: products of alpha terms.
  logic        s2_valid_q;
  logic [15:0] s2_s_q;
  logic [23:0] s2_sa255_q, s2_sa255_d;
  logic [23:0] s2_adt_q, s2_adt_d;
  logic [23:0] s2_cs_q [3];
  logic [23:0] s2_cs_d [3];
  pix_in_t     s2_px_q;
  mode_e       s2_mode_q;

  // Stage 3: colour terms and result alpha.
  logic        s3_valid_q;
  logic [15:0] s3_s_q;
  logic [23:0] s3_bp_q, s3_bp_d;
  logic [31:0] s3_x1_q [3];
  logic [31:0] s3_x1_d [3];
  logic [31:0] s3_x2_q [3];
  logic [31:0] s3_x2_d [3];
  pix_in_t     s3_px_q;
  mode_e       s3_mode_q;

  // Stage 4: divider operands.
  logic            s4_valid_q;
  logic [NumW-1:0] s4_num_q [Lanes];
  logic [NumW-1:0] s4_num_d [Lanes];
  logic [DenW-1:0] s4_den_q [Lanes];
  logic [DenW-1:0] s4_den_d [Lanes];
  side_t           s4_side_q, s4_side_d;

  logic [7:0]  mm;
  logic [15:0] t;
  logic [7:0]  cs1 [3];
  logic [7:0]  cd2 [3];
  logic [7:0]  cd3 [3];
  logic [31:0] n4;

  always_comb begin
    mm     = (mode_i == MODE_BLEND) ? ALPHA_ONE : px_i.ma;
    s1_s_d = 16'(mm) * 16'(px_i.sa);
  end

  always_comb begin
    cs1[0]     = s1_px_q.sr;
    cs1[1]     = s1_px_q.sg;
    cs1[2]     = s1_px_q.sb;
    t          = ALPHA_SQ - s1_s_q;
    s2_sa255_d = (24'(s1_s_q) << 8) - 24'(s1_s_q);
    s2_adt_d   = 24'(s1_px_q.da) * 24'(t);
    for (int c = 0; c < 3; c++) begin
      s2_cs_d[c] = 24'(cs1[c]) * 24'(s1_s_q);
    end
  end

  always_comb begin
    cd2[0]  = s2_px_q.dr;
    cd2[1]  = s2_px_q.dg;
    cd2[2]  = s2_px_q.db;
    s3_bp_d = s2_sa255_q + s2_adt_q;
    for (int c = 0; c < 3; c++) begin
      s3_x1_d[c] = (32'(s2_cs_q[c]) << 8) - 32'(s2_cs_q[c]);
      s3_x2_d[c] = 32'(cd2[c]) * 32'(s2_adt_q);
    end
  end

  always_comb begin
    cd3[0] = s3_px_q.dr;
    cd3[1] = s3_px_q.dg;
    cd3[2] = s3_px_q.db;
    n4     = '0;
    for (int c = 0; c < 3; c++) begin
      n4          = s3_x1_q[c] + s3_x2_q[c];
      s4_num_d[c] = (NumW'(n4) << 1) + NumW'(s3_bp_q);
      s4_den_d[c] = {s3_bp_q, 1'b0};
    end
    if (s3_mode_q == MODE_MASK_COPY) begin
      s4_num_d[AlphaLane] = (NumW'(s3_s_q) << 1) + NumW'(ALPHA_ONE);
      s4_den_d[AlphaLane] = MCOPY_DIV;
    end else begin
      s4_num_d[AlphaLane] = (NumW'(s3_bp_q) << 1) + NumW'(ALPHA_SQ);
      s4_den_d[AlphaLane] = ALPHA_DIV;
    end
    s4_side_d.sr = s3_px_q.sr;
    s4_side_d.sg = s3_px_q.sg;
    s4_side_d.sb = s3_px_q.sb;
    s4_side_d.sa = s3_px_q.sa;
    s4_side_d.dr = s3_px_q.dr;
    s4_side_d.dg = s3_px_q.dg;
    s4_side_d.db = s3_px_q.db;
    s4_side_d.da = s3_px_q.da;
    unique case (s3_mode_q)
      MODE_COPY:       s4_side_d.sel = SEL_SRC;
      MODE_MASK_COPY:  s4_side_d.sel = SEL_SRC_DIVA;
      MODE_MASK_BLEND: s4_side_d.sel = (s3_s_q == '0) ? SEL_DST : SEL_DIV;
      MODE_BLEND:      s4_side_d.sel = (s3_bp_q == '0) ? SEL_ZERO : SEL_DIV;
      default:         s4_side_d.sel = SEL_DIV;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_s_q     <= s1_s_d;
      s1_px_q    <= px_i;
      s1_mode_q  <= mode_i;
      s2_s_q     <= s1_s_q;
      s2_sa255_q <= s2_sa255_d;
      s2_adt_q   <= s2_adt_d;
      s2_cs_q    <= s2_cs_d;
      s2_px_q    <= s1_px_q;
      s2_mode_q  <= s1_mode_q;
      s3_s_q     <= s2_s_q;
      s3_bp_q    <= s3_bp_d;
      s3_x1_q    <= s3_x1_d;
      s3_x2_q    <= s3_x2_d;
      s3_px_q    <= s2_px_q;
      s3_mode_q  <= s2_mode_q;
      s4_num_q   <= s4_num_d;
      s4_den_q   <= s4_den_d;
      s4_side_q  <= s4_side_d;
    end
  end

  assign valid_o = s4_valid_q;
  assign num_o   = s4_num_q;
  assign den_o   = s4_den_q;
  assign side_o  = s4_side_q;

endmodule

// ===== src/asoc_divider.sv =====
// ----------------------------------------------------------------------------
// asoc_divider
// Pipelined restoring divider, two quotient bits per stage on every lane.
// ----------------------------------------------------------------------------
module asoc_divider import asoc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NumW-1:0]  num_i [Lanes],
  input  logic [DenW-1:0]  den_i [Lanes],
  input  side_t            side_i,
  output logic             valid_o,
  output logic [QuotW-1:0] quot_o [Lanes],
  output side_t            side_o
);

  logic             v_q    [DivStages];
  logic [NumW-1:0]  rem_q  [DivStages][Lanes];
  logic [NumW-1:0]  rem_d  [DivStages][Lanes];
  logic [DenW-1:0]  den_q  [DivStages][Lanes];
  logic [QuotW-1:0] quo_q  [DivStages][Lanes];
  logic [QuotW-1:0] quo_d  [DivStages][Lanes];
  side_t            side_q [DivStages];

  // The dividend is always below 256 times the divisor, so eight bits suffice.
  always_comb begin
    logic [NumW-1:0]  r;
    logic [DenW-1:0]  d;
    logic [QuotW-1:0] q;
    step_t            st;
    for (int k = 0; k < DivStages; k++) begin
      for (int l = 0; l < Lanes; l++) begin
        if (k == 0) begin
          r = num_i[l];
          d = den_i[l];
          q = '0;
        end else begin
          r = rem_q[k-1][l];
          d = den_q[k-1][l];
          q = quo_q[k-1][l];
        end
        for (int j = 0; j < StepsPerStage; j++) begin
          st = div_step(r, d, QuotW - 1 - k * StepsPerStage - j);
          r  = st.rem;
          q[QuotW - 1 - k * StepsPerStage - j] = st.qbit;
        end
        rem_d[k][l] = r;
        quo_d[k][l] = q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivStages; k++) begin
        v_q[k] <= 1'b0;
      end
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < DivStages; k++) begin
        v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q     <= rem_d;
      quo_q     <= quo_d;
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
      for (int k = 1; k < DivStages; k++) begin
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = v_q[DivStages-1];
  assign quot_o  = quo_q[DivStages-1];
  assign side_o  = side_q[DivStages-1];

endmodule

// ===== src/alpha_source_over_composite.sv =====
// ----------------------------------------------------------------------------
// alpha_source_over_composite
// Per-pixel source-over compositing with mask alpha and four modes.
// ----------------------------------------------------------------------------
// Pixels enter on the in channel (valid/ready) with source RGBA, destination
// RGBA and mask alpha, and leave on the out channel with the composited RGBA
// and a write enable. The mode register is written through cfg_we_i and
// cfg_wdata_i; write it only while no request is in flight, which the block
// itself does not enforce. A request passes through four stages of alpha and
// colour products, four divider stages resolving two quotient bits each, and
// the output register before its result appears on the out channel.
// Throughput is one pixel per cycle while results are taken; every stage is a
// plain register stage and the divider is fully pipelined per lane.
// Reset clears all valid bits and sets the mode to blend.
// When the receiver stalls with a result held, the whole pipeline freezes and
// in_ready_o drops; nothing is dropped or repeated, and flow resumes in the
// cycle the result is taken.
// ----------------------------------------------------------------------------
module alpha_source_over_composite import asoc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] src_red_i,
  input  logic [7:0] src_green_i,
  input  logic [7:0] src_blue_i,
  input  logic [7:0] src_alpha_i,
  input  logic [7:0] dst_red_i,
  input  logic [7:0] dst_green_i,
  input  logic [7:0] dst_blue_i,
  input  logic [7:0] dst_alpha_i,
  input  logic [7:0] mask_alpha_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_alpha_o,
  output logic       write_enable_o
);

  mode_e   mode_q;
  logic    en;
  pix_in_t px;

  logic            f_valid;
  logic [NumW-1:0] f_num [Lanes];
  logic [DenW-1:0] f_den [Lanes];
  side_t           f_side;

  logic             d_valid;
  logic [QuotW-1:0] d_quot [Lanes];
  side_t            d_side;

  logic       out_valid_q;
  logic [7:0] red_q, red_d, green_q, green_d, blue_q, blue_d, alpha_q, alpha_d;
  logic       we_q, we_d;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BLEND;
    end else if (cfg_we_i) begin
      mode_q <= mode_e'(cfg_wdata_i);
    end
  end

  always_comb begin
    px.sr = src_red_i;
    px.sg = src_green_i;
    px.sb = src_blue_i;
    px.sa = src_alpha_i;
    px.dr = dst_red_i;
    px.dg = dst_green_i;
    px.db = dst_blue_i;
    px.da = dst_alpha_i;
    px.ma = mask_alpha_i;
  end

  asoc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .mode_i  (mode_q),
    .px_i    (px),
    .valid_o (f_valid),
    .num_o   (f_num),
    .den_o   (f_den),
    .side_o  (f_side)
  );

  asoc_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .num_i   (f_num),
    .den_i   (f_den),
    .side_i  (f_side),
    .valid_o (d_valid),
    .quot_o  (d_quot),
    .side_o  (d_side)
  );

  always_comb begin
    red_d   = d_quot[0];
    green_d = d_quot[1];
    blue_d  = d_quot[2];
    alpha_d = d_quot[AlphaLane];
    we_d    = 1'b1;
    case (d_side.sel)
      SEL_SRC: begin
        red_d   = d_side.sr;
        green_d = d_side.sg;
        blue_d  = d_side.sb;
        alpha_d = d_side.sa;
      end
      SEL_SRC_DIVA: begin
        red_d   = d_side.sr;
        green_d = d_side.sg;
        blue_d  = d_side.sb;
      end
      SEL_DST: begin
        red_d   = d_side.dr;
        green_d = d_side.dg;
        blue_d  = d_side.db;
        alpha_d = d_side.da;
        we_d    = 1'b0;
      end
      SEL_ZERO: begin
        red_d   = '0;
        green_d = '0;
        blue_d  = '0;
        alpha_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      alpha_q <= alpha_d;
      we_q    <= we_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_red_o      = red_q;
  assign out_green_o    = green_q;
  assign out_blue_o     = blue_q;
  assign out_alpha_o    = alpha_q;
  assign write_enable_o = we_q;

`ifndef SYNTHESIS
  // A skipped write only comes from the mask-scaled blend.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |-> mode_q == MODE_MASK_BLEND)
    else $error("write skipped outside mask-scaled blend");

  // The pipeline only holds back requests while a result is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  // A stalled result is held on the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_alpha_o))
    else $error("stalled result changed");
`endif

endmodule
